[design/rgbcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcf_pkg
// Shared types, codes and constant tables of the RGB colour-cycle fader:
// request kinds, register indexes, the walk tables and the microcode ROM.
// ----------------------------------------------------------------------------
package rgbcf_pkg;

   // Fixed field widths
   localparam int KIND_W    = 2;
   localparam int ELAPSED_W = 16;
   localparam int SETLVL_W  = 13;
   localparam int SPEED_W   = 16;
   localparam int BRIGHT_W  = 13;
   localparam int FSCALE_W  = 16;
   localparam int DUTY_W    = 16;
   localparam int PHASE_W   = 3;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;
   localparam int BRIGHT_FRAC = 12;

   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [PHASE_W-1:0] phase_type;
   typedef logic [1:0]         chan_type;
   typedef logic [3:0]         uaddr_type;
   typedef logic [3:0]         walk_cnt_type;
   typedef logic [1:0]         csr_index_type;

   // Request kinds
   localparam kind_type KIND_TICK  = 2'd0;
   localparam kind_type KIND_START = 2'd1;
   localparam kind_type KIND_STOP  = 2'd2;
   localparam kind_type KIND_SET   = 2'd3;

   // Register indexes
   localparam csr_index_type REG_PATTERN = 2'd0;
   localparam csr_index_type REG_SPEED   = 2'd1;
   localparam csr_index_type REG_BRIGHT  = 2'd2;
   localparam csr_index_type REG_FSCALE  = 2'd3;

   // Register reset values and limits
   localparam logic [SPEED_W-1:0]  SPEED_RESET  = 16'd4096;
   localparam logic [BRIGHT_W-1:0] BRIGHT_ONE   = 13'd4096;
   localparam logic [FSCALE_W-1:0] FSCALE_RESET = 16'd255;

   // Channels
   localparam chan_type CH_RED   = 2'd0;
   localparam chan_type CH_GREEN = 2'd1;
   localparam chan_type CH_BLUE  = 2'd2;

   // Patterns and phase limits
   localparam logic      PAT_RAMP   = 1'b0;
   localparam logic      PAT_XFADE  = 1'b1;
   localparam phase_type RAMP_LAST  = 3'd5;
   localparam phase_type XF_LAST    = 3'd2;
   localparam walk_cnt_type WALK_LAST = 4'd15;

   // Single-channel ramp: which channel moves in each phase
   function automatic chan_type ramp_chan_fn(input phase_type ph);
      chan_type c;
      case (ph)
         3'd0:    c = CH_GREEN;
         3'd1:    c = CH_RED;
         3'd2:    c = CH_BLUE;
         3'd3:    c = CH_GREEN;
         3'd4:    c = CH_RED;
         3'd5:    c = CH_BLUE;
         default: c = CH_GREEN;
      endcase
      return c;
   endfunction

   // Single-channel ramp: direction of each phase
   function automatic logic ramp_up_fn(input phase_type ph);
      logic u;
      case (ph)
         3'd0:    u = 1'b1;
         3'd1:    u = 1'b0;
         3'd2:    u = 1'b1;
         3'd3:    u = 1'b0;
         3'd4:    u = 1'b1;
         3'd5:    u = 1'b0;
         default: u = 1'b1;
      endcase
      return u;
   endfunction

   // Crossfade: channel that rises
   function automatic chan_type xf_up_fn(input phase_type ph);
      chan_type c;
      case (ph)
         3'd0:    c = CH_BLUE;
         3'd1:    c = CH_RED;
         3'd2:    c = CH_GREEN;
         default: c = CH_BLUE;
      endcase
      return c;
   endfunction

   // Crossfade: channel that falls
   function automatic chan_type xf_down_fn(input phase_type ph);
      chan_type c;
      case (ph)
         3'd0:    c = CH_RED;
         3'd1:    c = CH_GREEN;
         3'd2:    c = CH_BLUE;
         default: c = CH_RED;
      endcase
      return c;
   endfunction

   // Sequencer branch conditions
   typedef enum logic [2:0] {
      COND_SEQ,
      COND_JUMP,
      COND_WAIT_REQ,
      COND_SKIP_IDLE,
      COND_LOOP_WALK,
      COND_WAIT_OUT
   } cond_type;

   // One control word of the program
   typedef struct packed {
      logic      take;
      logic      exec;
      logic      modr;
      logic      walk;
      logic      mul1;
      chan_type  mul_chan;
      logic      mul2;
      logic      keep;
      chan_type  keep_chan;
      logic      load_out;
      cond_type  cond;
      uaddr_type target;
   } ucode_type;

   // Status that steers the sequencer
   typedef struct packed {
      logic req_valid;
      logic tick_run;
      logic walk_more;
      logic out_free;
   } seq_status_type;

   // Program addresses
   localparam uaddr_type UA_IDLE  = 4'd0;
   localparam uaddr_type UA_EXEC  = 4'd1;
   localparam uaddr_type UA_MOD   = 4'd2;
   localparam uaddr_type UA_WALK  = 4'd3;
   localparam uaddr_type UA_DUTY0 = 4'd4;
   localparam uaddr_type UA_DUTY1 = 4'd5;
   localparam uaddr_type UA_DUTY2 = 4'd6;
   localparam uaddr_type UA_DUTY3 = 4'd7;
   localparam uaddr_type UA_DUTY4 = 4'd8;
   localparam uaddr_type UA_OUT   = 4'd9;

   // Microcode ROM
   function automatic ucode_type ucode_rom(input uaddr_type addr);
      ucode_type w;
      w        = '0;
      w.cond   = COND_SEQ;
      w.target = UA_IDLE;
      case (addr)
         UA_IDLE: begin
            w.take = 1'b1;
            w.cond = COND_WAIT_REQ;
         end
         UA_EXEC: begin
            w.exec   = 1'b1;
            w.cond   = COND_SKIP_IDLE;
            w.target = UA_DUTY0;
         end
         UA_MOD: begin
            w.modr = 1'b1;
         end
         UA_WALK: begin
            w.walk = 1'b1;
            w.cond = COND_LOOP_WALK;
         end
         UA_DUTY0: begin
            w.mul1     = 1'b1;
            w.mul_chan = CH_RED;
         end
         UA_DUTY1: begin
            w.mul2     = 1'b1;
            w.mul1     = 1'b1;
            w.mul_chan = CH_GREEN;
         end
         UA_DUTY2: begin
            w.keep      = 1'b1;
            w.keep_chan = CH_RED;
            w.mul2      = 1'b1;
            w.mul1      = 1'b1;
            w.mul_chan  = CH_BLUE;
         end
         UA_DUTY3: begin
            w.keep      = 1'b1;
            w.keep_chan = CH_GREEN;
            w.mul2      = 1'b1;
         end
         UA_DUTY4: begin
            w.keep      = 1'b1;
            w.keep_chan = CH_BLUE;
         end
         UA_OUT: begin
            w.load_out = 1'b1;
            w.cond     = COND_WAIT_OUT;
            w.target   = UA_IDLE;
         end
         default: begin
            w.cond   = COND_JUMP;
            w.target = UA_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[design/rgbcf_useq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbcf_useq
// Step counter and microcode ROM: presents the control word of the current
// step and picks the next step from the branch condition of that word.
// ----------------------------------------------------------------------------
module rgbcf_useq import rgbcf_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire seq_status_type status,
   output ucode_type           ctrl
);

   uaddr_type upc_ff;
   uaddr_type upc_in;

   // Fetch the control word
   assign ctrl = ucode_rom(upc_ff);

   // Select the next step
   always_comb begin
      case (ctrl.cond)
         COND_SEQ:       upc_in = upc_ff + 4'd1;
         COND_JUMP:      upc_in = ctrl.target;
         COND_WAIT_REQ:  upc_in = status.req_valid ? upc_ff + 4'd1 : upc_ff;
         COND_SKIP_IDLE: upc_in = status.tick_run ? upc_ff + 4'd1 : ctrl.target;
         COND_LOOP_WALK: upc_in = status.walk_more ? upc_ff : upc_ff + 4'd1;
         COND_WAIT_OUT:  upc_in = status.out_free ? ctrl.target : upc_ff;
         default:        upc_in = UA_IDLE;
      endcase
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule
`default_nettype wire

[design/rgbcf_walk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbcf_walk
// One phase of the color walk: moves the active channel(s) of the current
// phase by the remaining distance and reports whether an overshoot carries
// into the next phase.
// ----------------------------------------------------------------------------
module rgbcf_walk import rgbcf_pkg::*; #(
   parameter int  LEVEL_FRAC_BITS = 12,
   localparam int LW = LEVEL_FRAC_BITS + 1,
   localparam int DW = LEVEL_FRAC_BITS + 3
) (
   input  wire logic          pattern,
   input  wire phase_type     phase,
   input  wire logic [DW-1:0] dist_in,
   input  wire logic [LW-1:0] lvl_red,
   input  wire logic [LW-1:0] lvl_green,
   input  wire logic [LW-1:0] lvl_blue,
   output logic [LW-1:0]      lvl_red_out,
   output logic [LW-1:0]      lvl_green_out,
   output logic [LW-1:0]      lvl_blue_out,
   output phase_type          phase_out,
   output logic [DW-1:0]      dist_out,
   output logic               carry
);

   localparam logic [LW-1:0] LVL_ONE = LW'(1) << LEVEL_FRAC_BITS;
   localparam logic [DW-1:0] D_ONE   = DW'(1) << LEVEL_FRAC_BITS;

   chan_type      chan_a;
   chan_type      chan_b;
   logic [LW-1:0] lv_a;
   logic [LW-1:0] lv_b;
   logic [DW-1:0] sum_a;
   logic          hit_up;
   logic          hit_dn_a;
   logic          hit_dn_b;
   logic [DW-1:0] over_u;
   logic [DW-1:0] over_d;
   logic [LW-1:0] new_a;
   logic [LW-1:0] new_b;
   logic          wr_a;
   logic          wr_b;
   phase_type     last;

   function automatic logic [LW-1:0] pick(input chan_type c, input logic [LW-1:0] r,
                                          input logic [LW-1:0] g, input logic [LW-1:0] b);
      logic [LW-1:0] v;
      case (c)
         CH_RED:   v = r;
         CH_GREEN: v = g;
         CH_BLUE:  v = b;
         default:  v = r;
      endcase
      return v;
   endfunction

   // Read the channels of this phase
   always_comb begin
      chan_a   = (pattern == PAT_XFADE) ? xf_up_fn(phase) : ramp_chan_fn(phase);
      chan_b   = xf_down_fn(phase);
      lv_a     = pick(chan_a, lvl_red, lvl_green, lvl_blue);
      lv_b     = pick(chan_b, lvl_red, lvl_green, lvl_blue);
      sum_a    = DW'(lv_a) + dist_in;
      hit_up   = sum_a >= D_ONE;
      hit_dn_a = dist_in >= DW'(lv_a);
      hit_dn_b = dist_in >= DW'(lv_b);
      over_u   = hit_up ? sum_a - D_ONE : '0;
      over_d   = hit_dn_b ? dist_in - DW'(lv_b) : '0;
   end

   // Move the levels and work out the carry
   always_comb begin
      new_a    = lv_a;
      new_b    = lv_b;
      wr_a     = 1'b1;
      wr_b     = 1'b0;
      dist_out = dist_in;
      carry    = 1'b0;
      if (pattern == PAT_RAMP) begin
         if (ramp_up_fn(phase)) begin
            if (hit_up) begin
               new_a    = LVL_ONE;
               dist_out = sum_a - D_ONE;
               carry    = 1'b1;
            end else begin
               new_a = sum_a[LW-1:0];
            end
         end else begin
            if (hit_dn_a) begin
               new_a    = '0;
               dist_out = dist_in - DW'(lv_a);
               carry    = 1'b1;
            end else begin
               new_a = lv_a - dist_in[LW-1:0];
            end
         end
      end else begin
         wr_b = 1'b1;
         if (hit_up || hit_dn_b) begin
            new_a    = LVL_ONE;
            new_b    = '0;
            dist_out = (over_u > over_d) ? over_u : over_d;
            carry    = 1'b1;
         end else begin
            new_a = sum_a[LW-1:0];
            new_b = lv_b - dist_in[LW-1:0];
         end
      end
   end

   // Write back the moved channels and step the phase
   always_comb begin
      lvl_red_out   = lvl_red;
      lvl_green_out = lvl_green;
      lvl_blue_out  = lvl_blue;
      if (wr_b) begin
         case (chan_b)
            CH_RED:   lvl_red_out   = new_b;
            CH_GREEN: lvl_green_out = new_b;
            CH_BLUE:  lvl_blue_out  = new_b;
            default:  lvl_red_out   = lvl_red;
         endcase
      end
      if (wr_a) begin
         case (chan_a)
            CH_RED:   lvl_red_out   = new_a;
            CH_GREEN: lvl_green_out = new_a;
            CH_BLUE:  lvl_blue_out  = new_a;
            default:  lvl_red_out   = lvl_red;
         endcase
      end
      last      = (pattern == PAT_XFADE) ? XF_LAST : RAMP_LAST;
      phase_out = phase;
      if (carry) begin
         phase_out = (phase == last) ? '0 : phase + 3'd1;
      end
   end

endmodule
`default_nettype wire

[design/rgb_color_cycle_fader.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_color_cycle_fader
// RGB color-cycle LED fader with a microcoded control sequencer.
// ----------------------------------------------------------------------------
// Each request (tick, start, stop or set color) may change the three color
// levels, the phase and the running flag, and returns one result with the
// three PWM duties level * brightness * full scale >> (LEVEL_FRAC_BITS + 12),
// the phase and the running flag. Requests are handled one at a time by a
// ten-step microcode program: start, stop, set color and a tick while stopped
// pass the take, execute, duty and output steps; a tick while running also
// passes the reduction step and walks N phases (1 to 16), one phase per
// cycle in the walk unit. The three duties share one two-stage multiplier.
// A result waits in the output register while the next request is accepted;
// the sequencer holds at its last step only if an older result has not yet
// been taken. Registers are written through the APB port; the user must do
// so only while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module rgb_color_cycle_fader import rgbcf_pkg::*; #(
   parameter int LEVEL_FRAC_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [ELAPSED_W-1:0] req_elapsed_ms,
   input  wire logic [SETLVL_W-1:0]  req_set_red,
   input  wire logic [SETLVL_W-1:0]  req_set_green,
   input  wire logic [SETLVL_W-1:0]  req_set_blue,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [DUTY_W-1:0]         rsp_duty_red,
   output logic [DUTY_W-1:0]         rsp_duty_green,
   output logic [DUTY_W-1:0]         rsp_duty_blue,
   output logic [PHASE_W-1:0]        rsp_fade_phase,
   output logic                      rsp_fading,
   // register port
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [CSR_AW-1:0]    paddr,
   input  wire logic [CSR_DW-1:0]    pwdata,
   output logic [CSR_DW-1:0]         prdata,
   output logic                      pready
);

   localparam int LW       = LEVEL_FRAC_BITS + 1;
   localparam int DW       = LEVEL_FRAC_BITS + 3;
   localparam int CMPW     = (LW > SETLVL_W) ? LW : SETLVL_W;
   localparam int P1W      = LW + BRIGHT_W;
   localparam int P2W      = P1W + FSCALE_W;
   localparam int DUTY_LSB = LEVEL_FRAC_BITS + BRIGHT_FRAC;
   localparam logic [LW-1:0] LVL_ONE = LW'(1) << LEVEL_FRAC_BITS;

   // Registers
   logic                 pattern_ff;
   logic [SPEED_W-1:0]   speed_ff;
   logic [BRIGHT_W-1:0]  bright_ff;
   logic [FSCALE_W-1:0]  fscale_ff;

   // State
   logic [LW-1:0]        lvl_red_ff;
   logic [LW-1:0]        lvl_green_ff;
   logic [LW-1:0]        lvl_blue_ff;
   phase_type            phase_ff;
   logic                 running_ff;

   // Captured request and datapath
   kind_type             kind_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [SETLVL_W-1:0]  set_red_ff;
   logic [SETLVL_W-1:0]  set_green_ff;
   logic [SETLVL_W-1:0]  set_blue_ff;
   logic [31:0]          prod_ff;
   logic [DW-1:0]        dist_ff;
   walk_cnt_type         walk_cnt_ff;
   logic [P1W-1:0]       p1_ff;
   logic [P2W-1:0]       p2_ff;
   logic [DUTY_W-1:0]    duty_red_ff;
   logic [DUTY_W-1:0]    duty_green_ff;
   logic [DUTY_W-1:0]    duty_blue_ff;

   // Result register
   logic                 rsp_valid_ff;
   logic [DUTY_W-1:0]    rsp_red_ff;
   logic [DUTY_W-1:0]    rsp_green_ff;
   logic [DUTY_W-1:0]    rsp_blue_ff;
   phase_type            rsp_phase_ff;
   logic                 rsp_fading_ff;

   ucode_type            ctrl;
   seq_status_type       status;
   logic                 csr_wr;
   csr_index_type        csr_idx;
   logic [BRIGHT_W-1:0]  bright_wr;
   logic [31:0]          cyc_q;
   logic [1:0]           rem3;
   logic [2:0]           rem_cyc;
   logic [LW-1:0]        mul_lvl;
   logic [LW-1:0]        walk_red;
   logic [LW-1:0]        walk_green;
   logic [LW-1:0]        walk_blue;
   phase_type            walk_phase;
   logic [DW-1:0]        walk_dist;
   logic                 walk_carry;

   // Remainder by three: sum base-4 digits, then fold
   function automatic logic [1:0] mod3_fn(input logic [31:0] v);
      logic [5:0] s1;
      logic [3:0] s2;
      logic [2:0] s3;
      s1 = '0;
      for (int i = 0; i < 16; i++) begin
         s1 = s1 + 6'(v[2*i +: 2]);
      end
      s2 = 4'(s1[5:4]) + 4'(s1[3:2]) + 4'(s1[1:0]);
      s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
      if (s3 >= 3'd3) begin
         s3 = s3 - 3'd3;
      end
      return s3[1:0];
   endfunction

   // Remainder by six from the remainder by three and the parity
   function automatic logic [2:0] mod6_fn(input logic [1:0] r3, input logic odd);
      logic [2:0] r;
      case ({r3, odd})
         3'b000:  r = 3'd0;
         3'b001:  r = 3'd3;
         3'b010:  r = 3'd4;
         3'b011:  r = 3'd1;
         3'b100:  r = 3'd2;
         3'b101:  r = 3'd5;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   // Saturate a set-color level to full
   function automatic logic [LW-1:0] clamp_fn(input logic [SETLVL_W-1:0] v);
      logic [LW-1:0] r;
      if (CMPW'(v) > CMPW'(LVL_ONE)) begin
         r = LVL_ONE;
      end else begin
         r = LW'(v);
      end
      return r;
   endfunction

   // Sequencer
   rgbcf_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign status.req_valid = req_valid;
   assign status.tick_run  = (kind_ff == KIND_TICK) && running_ff;
   assign status.walk_more = walk_carry && (walk_cnt_ff != WALK_LAST);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // One walk phase
   rgbcf_walk #(
      .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
   ) u_walk (
      .pattern       (pattern_ff),
      .phase         (phase_ff),
      .dist_in       (dist_ff),
      .lvl_red       (lvl_red_ff),
      .lvl_green     (lvl_green_ff),
      .lvl_blue      (lvl_blue_ff),
      .lvl_red_out   (walk_red),
      .lvl_green_out (walk_green),
      .lvl_blue_out  (walk_blue),
      .phase_out     (walk_phase),
      .dist_out      (walk_dist),
      .carry         (walk_carry)
   );

   // Register port decode and read-back
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_idx   = paddr[3:2];
   assign bright_wr = (pwdata[BRIGHT_W-1:0] > BRIGHT_ONE) ? BRIGHT_ONE
                                                          : pwdata[BRIGHT_W-1:0];

   always_comb begin
      case (csr_idx)
         REG_PATTERN: prdata = CSR_DW'(pattern_ff);
         REG_SPEED:   prdata = CSR_DW'(speed_ff);
         REG_BRIGHT:  prdata = CSR_DW'(bright_ff);
         REG_FSCALE:  prdata = CSR_DW'(fscale_ff);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PAT_RAMP;
         speed_ff   <= SPEED_RESET;
         bright_ff  <= BRIGHT_ONE;
         fscale_ff  <= FSCALE_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_PATTERN: pattern_ff <= pwdata[0];
            REG_SPEED: begin
               if (pwdata[SPEED_W-1:0] != '0) speed_ff <= pwdata[SPEED_W-1:0];
            end
            REG_BRIGHT:  bright_ff <= bright_wr;
            REG_FSCALE: begin
               if (pwdata[FSCALE_W-1:0] != '0) fscale_ff <= pwdata[FSCALE_W-1:0];
            end
            default:     pattern_ff <= pattern_ff;
         endcase
      end
   end

   // Reduce the tick distance modulo one full cycle
   assign cyc_q   = prod_ff >> LEVEL_FRAC_BITS;
   assign rem3    = mod3_fn(cyc_q);
   assign rem_cyc = (pattern_ff == PAT_XFADE) ? 3'(rem3) : mod6_fn(rem3, cyc_q[0]);

   // Level feeding the duty multiplier
   always_comb begin
      case (ctrl.mul_chan)
         CH_RED:   mul_lvl = lvl_red_ff;
         CH_GREEN: mul_lvl = lvl_green_ff;
         CH_BLUE:  mul_lvl = lvl_blue_ff;
         default:  mul_lvl = lvl_red_ff;
      endcase
   end

   // Capture the request; accept nothing while in reset
   assign req_ready = ctrl.take && !reset;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff      <= req_kind;
         elapsed_ff   <= req_elapsed_ms;
         set_red_ff   <= req_set_red;
         set_green_ff <= req_set_green;
         set_blue_ff  <= req_set_blue;
      end
   end

   // Color state: commands, reduction and walk
   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_red_ff   <= '0;
         lvl_green_ff <= '0;
         lvl_blue_ff  <= '0;
         phase_ff     <= '0;
         running_ff   <= 1'b0;
         walk_cnt_ff  <= '0;
      end else begin
         if (ctrl.exec) begin
            case (kind_ff)
               KIND_START: begin
                  lvl_red_ff   <= LVL_ONE;
                  lvl_green_ff <= (pattern_ff == PAT_XFADE) ? LVL_ONE : '0;
                  lvl_blue_ff  <= '0;
                  phase_ff     <= '0;
                  running_ff   <= 1'b1;
               end
               KIND_STOP: begin
                  running_ff <= 1'b0;
               end
               KIND_SET: begin
                  lvl_red_ff   <= clamp_fn(set_red_ff);
                  lvl_green_ff <= clamp_fn(set_green_ff);
                  lvl_blue_ff  <= clamp_fn(set_blue_ff);
                  running_ff   <= 1'b0;
               end
               default: begin
                  running_ff <= running_ff;
               end
            endcase
         end
         if (ctrl.modr) begin
            walk_cnt_ff <= '0;
            if ((pattern_ff == PAT_XFADE) ? (phase_ff > XF_LAST) : (phase_ff > RAMP_LAST)) begin
               phase_ff <= '0;
            end
         end
         if (ctrl.walk) begin
            lvl_red_ff   <= walk_red;
            lvl_green_ff <= walk_green;
            lvl_blue_ff  <= walk_blue;
            phase_ff     <= walk_phase;
            walk_cnt_ff  <= walk_cnt_ff + 4'd1;
         end
      end
   end

   // Tick product, reduced distance, duty multiplier
   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         prod_ff <= 32'(elapsed_ff) * 32'(speed_ff);
      end
      if (ctrl.modr) begin
         dist_ff <= {rem_cyc, prod_ff[LEVEL_FRAC_BITS-1:0]};
      end else if (ctrl.walk) begin
         dist_ff <= walk_dist;
      end
      if (ctrl.mul1) begin
         p1_ff <= P1W'(mul_lvl) * P1W'(bright_ff);
      end
      if (ctrl.mul2) begin
         p2_ff <= P2W'(p1_ff) * P2W'(fscale_ff);
      end
      if (ctrl.keep) begin
         case (ctrl.keep_chan)
            CH_RED:   duty_red_ff   <= p2_ff[DUTY_LSB +: DUTY_W];
            CH_GREEN: duty_green_ff <= p2_ff[DUTY_LSB +: DUTY_W];
            CH_BLUE:  duty_blue_ff  <= p2_ff[DUTY_LSB +: DUTY_W];
            default:  duty_red_ff   <= duty_red_ff;
         endcase
      end
   end

   // Result register: load when free, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_out && status.out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out && status.out_free) begin
         rsp_red_ff    <= duty_red_ff;
         rsp_green_ff  <= duty_green_ff;
         rsp_blue_ff   <= duty_blue_ff;
         rsp_phase_ff  <= phase_ff;
         rsp_fading_ff <= running_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty_red   = rsp_red_ff;
   assign rsp_duty_green = rsp_green_ff;
   assign rsp_duty_blue  = rsp_blue_ff;
   assign rsp_fade_phase = rsp_phase_ff;
   assign rsp_fading     = rsp_fading_ff;

endmodule
`default_nettype wire

[design/rgbcf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbcf_checker
// Port-level checks of the colour-cycle fader, bound to the top level.
// ----------------------------------------------------------------------------
module rgbcf_checker import rgbcf_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [DUTY_W-1:0]    rsp_duty_red,
   input wire logic [DUTY_W-1:0]    rsp_duty_green,
   input wire logic [DUTY_W-1:0]    rsp_duty_blue,
   input wire logic [PHASE_W-1:0]   rsp_fade_phase,
   input wire logic                 rsp_fading
);

   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   // Track requests accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) pending_in = pending_in + 2'd1;
      if (rsp_valid && rsp_ready) pending_in = pending_in - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty_red)
         && $stable(rsp_duty_green) && $stable(rsp_duty_blue)
         && $stable(rsp_fade_phase) && $stable(rsp_fading))
      else $error("stalled result changed");

   // Take one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Show only phases up to the last ramp phase
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fade_phase <= RAMP_LAST)
      else $error("phase out of range");

   // Never answer without a request, never have more than two outstanding
   a_pending: assert property (@(posedge clock) disable iff (reset)
      (pending_ff != 2'd3) && (!rsp_valid || pending_ff != 2'd0))
      else $error("result count does not match requests");

endmodule

bind rgb_color_cycle_fader rgbcf_checker u_rgbcf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_duty_red   (rsp_duty_red),
   .rsp_duty_green (rsp_duty_green),
   .rsp_duty_blue  (rsp_duty_blue),
   .rsp_fade_phase (rsp_fade_phase),
   .rsp_fading     (rsp_fading)
);
`default_nettype wire

[bench/tb_rgb_color_cycle_fader.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_color_cycle_fader
// Self-checking bench for the RGB color-cycle fader. A behavioral copy of the
// fader state (levels, phase, running flag, registers) predicts the duties,
// phase and flag of every accepted request. The checker compares each result
// in order. Directed tests cover register rules, both patterns and pattern
// changes while running. Random traffic runs under several register settings
// and idling mixes; another test adds one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_rgb_color_cycle_fader import rgbcf_pkg::*;;

   localparam int LVL_ONE         = 4096;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 135;
   localparam int SETTLE_CYCLES   = 30;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_red;
      logic [DUTY_W-1:0] duty_green;
      logic [DUTY_W-1:0] duty_blue;
      phase_type         phase;
      logic              fading;
   } fader_result_type;

   // DUT inputs start at known values
   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   kind_type             req_kind       = KIND_TICK;
   logic [ELAPSED_W-1:0] req_elapsed_ms = '0;
   logic [SETLVL_W-1:0]  req_set_red    = '0;
   logic [SETLVL_W-1:0]  req_set_green  = '0;
   logic [SETLVL_W-1:0]  req_set_blue   = '0;
   logic                 rsp_ready      = 1'b0;
   logic                 psel           = 1'b0;
   logic                 penable        = 1'b0;
   logic                 pwrite         = 1'b0;
   logic [CSR_AW-1:0]    paddr          = '0;
   logic [CSR_DW-1:0]    pwdata         = '0;

   logic                 req_ready;
   logic                 rsp_valid;
   logic [DUTY_W-1:0]    rsp_duty_red;
   logic [DUTY_W-1:0]    rsp_duty_green;
   logic [DUTY_W-1:0]    rsp_duty_blue;
   logic [PHASE_W-1:0]   rsp_fade_phase;
   logic                 rsp_fading;
   logic [CSR_DW-1:0]    prdata;
   logic                 pready;

   // Predicted fader state and registers
   logic                 pattern_q;
   logic [SPEED_W-1:0]   speed_q;
   logic [BRIGHT_W-1:0]  bright_q;
   logic [FSCALE_W-1:0]  fscale_q;
   logic [SETLVL_W-1:0]  level_q [3];
   phase_type            phase_q;
   logic                 running_q;

   fader_result_type     duty_expect_q [$];
   fader_result_type     oldest_duty;
   int                   mismatch_count = 0;
   int                   cycle_count    = 0;
   int                   send_idle_pct  = 0;
   int                   stall_pct      = 0;
   int                   hold_left      = 0;

   rgb_color_cycle_fader uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_elapsed_ms (req_elapsed_ms),
      .req_set_red    (req_set_red),
      .req_set_green  (req_set_green),
      .req_set_blue   (req_set_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_duty_red   (rsp_duty_red),
      .rsp_duty_green (rsp_duty_green),
      .rsp_duty_blue  (rsp_duty_blue),
      .rsp_fade_phase (rsp_fade_phase),
      .rsp_fading     (rsp_fading),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Drive result ready: forced hold-off first, random stalls otherwise
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void check_field(input string name, input int expected,
                                       input int actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         mismatch_count++;
      end
   endfunction

   // Compare each result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (duty_expect_q.size() == 0) begin
            $error("result with no request outstanding");
            mismatch_count++;
         end else begin
            oldest_duty = duty_expect_q.pop_front();
            check_field("duty_red", oldest_duty.duty_red, rsp_duty_red);
            check_field("duty_green", oldest_duty.duty_green, rsp_duty_green);
            check_field("duty_blue", oldest_duty.duty_blue, rsp_duty_blue);
            check_field("fade_phase", oldest_duty.phase, rsp_fade_phase);
            check_field("fading", oldest_duty.fading, rsp_fading);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Fader prediction
   // ------------------------------------------------------------------------
   task automatic fader_state_reset();
      pattern_q  = PAT_RAMP;
      speed_q    = SPEED_RESET;
      bright_q   = BRIGHT_ONE;
      fscale_q   = FSCALE_RESET;
      level_q[0] = '0;
      level_q[1] = '0;
      level_q[2] = '0;
      phase_q    = '0;
      running_q  = 1'b0;
   endtask

   // Channel moved in each single-channel ramp phase
   function automatic int ramp_channel(input phase_type p);
      case (p)
         3'd1, 3'd4: return CH_RED;
         3'd2, 3'd5: return CH_BLUE;
         default:    return CH_GREEN;
      endcase
   endfunction

   // Walk the six-phase ramp; even phases rise, odd phases fall
   task automatic ramp_walk(input longint unsigned remain);
      int              step;
      int              ch;
      longint unsigned lvl;
      if (phase_q > RAMP_LAST) phase_q = '0;
      for (step = 0; step <= WALK_LAST; step++) begin
         ch  = ramp_channel(phase_q);
         lvl = level_q[ch];
         if (!phase_q[0]) begin
            if (lvl + remain >= LVL_ONE) begin
               remain      = lvl + remain - LVL_ONE;
               level_q[ch] = LVL_ONE;
            end else begin
               level_q[ch] = lvl + remain;
               return;
            end
         end else begin
            if (remain >= lvl) begin
               remain      = remain - lvl;
               level_q[ch] = '0;
            end else begin
               level_q[ch] = lvl - remain;
               return;
            end
         end
         phase_q = (phase_q == RAMP_LAST) ? '0 : phase_q + 1'b1;
      end
   endtask

   // Walk the three-phase crossfade; the larger overshoot carries on
   task automatic crossfade_walk(input longint unsigned remain);
      int              step;
      int              up_ch;
      int              dn_ch;
      longint unsigned rise;
      longint unsigned fall;
      longint unsigned over_up;
      longint unsigned over_dn;
      logic            hit_up;
      logic            hit_dn;
      if (phase_q > XF_LAST) phase_q = '0;
      for (step = 0; step <= WALK_LAST; step++) begin
         dn_ch  = phase_q;
         up_ch  = (phase_q + 2) % 3;
         rise   = level_q[up_ch];
         rise   = rise + remain;
         fall   = level_q[dn_ch];
         hit_up = (rise >= LVL_ONE);
         hit_dn = (remain >= fall);
         if (!hit_up && !hit_dn) begin
            level_q[up_ch] = rise;
            level_q[dn_ch] = fall - remain;
            return;
         end
         over_up        = hit_up ? rise - LVL_ONE : 0;
         over_dn        = hit_dn ? remain - fall : 0;
         remain         = (over_up > over_dn) ? over_up : over_dn;
         level_q[up_ch] = LVL_ONE;
         level_q[dn_ch] = '0;
         phase_q        = (phase_q == XF_LAST) ? '0 : phase_q + 1'b1;
      end
   endtask

   // Apply one request to the state and queue the duties it should produce
   task automatic fader_step(input kind_type kind, input logic [ELAPSED_W-1:0] elapsed,
                             input logic [SETLVL_W-1:0] set_r,
                             input logic [SETLVL_W-1:0] set_g,
                             input logic [SETLVL_W-1:0] set_b);
      longint unsigned   span;
      longint unsigned   reduced;
      longint unsigned   prod;
      logic [DUTY_W-1:0] duty [3];
      fader_result_type  res;
      int                c;
      case (kind)
         KIND_TICK: begin
            if (running_q) begin
               span    = (pattern_q == PAT_XFADE) ? 3 * LVL_ONE : 6 * LVL_ONE;
               reduced = elapsed;
               reduced = (reduced * speed_q) % span;
               if (pattern_q == PAT_XFADE) crossfade_walk(reduced);
               else ramp_walk(reduced);
            end
         end
         KIND_START: begin
            level_q[CH_RED]   = LVL_ONE;
            level_q[CH_GREEN] = (pattern_q == PAT_XFADE) ? LVL_ONE : 0;
            level_q[CH_BLUE]  = '0;
            phase_q           = '0;
            running_q         = 1'b1;
         end
         KIND_STOP: begin
            running_q = 1'b0;
         end
         default: begin
            level_q[CH_RED]   = (set_r > LVL_ONE) ? LVL_ONE : set_r;
            level_q[CH_GREEN] = (set_g > LVL_ONE) ? LVL_ONE : set_g;
            level_q[CH_BLUE]  = (set_b > LVL_ONE) ? LVL_ONE : set_b;
            running_q         = 1'b0;
         end
      endcase
      for (c = 0; c < 3; c++) begin
         prod    = level_q[c];
         prod    = prod * bright_q * fscale_q;
         duty[c] = prod >> (12 + BRIGHT_FRAC);
      end
      res.duty_red   = duty[CH_RED];
      res.duty_green = duty[CH_GREEN];
      res.duty_blue  = duty[CH_BLUE];
      res.phase      = phase_q;
      res.fading     = running_q;
      duty_expect_q.push_back(res);
   endtask

   // Register write rules: zero speed or full scale ignored, brightness saturates
   task automatic register_update(input csr_index_type index, input logic [CSR_DW-1:0] value);
      case (index)
         REG_PATTERN: pattern_q = value[0];
         REG_SPEED:   if (value[SPEED_W-1:0] != 0) speed_q = value[SPEED_W-1:0];
         REG_BRIGHT:  bright_q = (value[BRIGHT_W-1:0] > BRIGHT_ONE) ? BRIGHT_ONE
                                                                  : value[BRIGHT_W-1:0];
         default:     if (value[FSCALE_W-1:0] != 0) fscale_q = value[FSCALE_W-1:0];
      endcase
   endtask

   function automatic logic [CSR_DW-1:0] register_value(input csr_index_type index);
      case (index)
         REG_PATTERN: return {31'd0, pattern_q};
         REG_SPEED:   return {16'd0, speed_q};
         REG_BRIGHT:  return {19'd0, bright_q};
         default:     return {16'd0, fscale_q};
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Bus and channel drivers (entered and left at a falling edge)
   // ------------------------------------------------------------------------
   task automatic csr_write(input csr_index_type index, input logic [CSR_DW-1:0] value);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = {index, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      register_update(index, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic csr_check(input csr_index_type index);
      logic [CSR_DW-1:0] got;
      psel    = 1'b1;
      pwrite  = 1'b0;
      penable = 1'b0;
      paddr   = {index, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      check_field("prdata", register_value(index), got);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(input kind_type kind, input logic [ELAPSED_W-1:0] elapsed,
                               input logic [SETLVL_W-1:0] set_r,
                               input logic [SETLVL_W-1:0] set_g,
                               input logic [SETLVL_W-1:0] set_b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_kind       = kind;
      req_elapsed_ms = elapsed;
      req_set_red    = set_r;
      req_set_green  = set_g;
      req_set_blue   = set_b;
      do @(posedge clock); while (!req_ready);
      fader_step(kind, elapsed, set_r, set_g, set_b);
      @(negedge clock);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic wait_drain();
      req_valid = 1'b0;
      while (duty_expect_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write a register once the block is idle, then read it back
   task automatic program_register(input csr_index_type index, input logic [CSR_DW-1:0] value);
      wait_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write(index, value);
      csr_check(index);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
   endtask

   // ------------------------------------------------------------------------
   // Random value pickers
   // ------------------------------------------------------------------------
   function automatic logic [SETLVL_W-1:0] pick_level();
      case ($urandom_range(7))
         0:       return '0;
         1:       return LVL_ONE;
         2:       return $urandom_range(8191, LVL_ONE + 1);
         default: return $urandom_range(LVL_ONE);
      endcase
   endfunction

   function automatic logic [ELAPSED_W-1:0] pick_elapsed();
      int sel;
      sel = $urandom_range(9);
      if (sel < 6) return $urandom_range(4);
      if (sel < 8) return $urandom_range(65535);
      return $urandom_range(300);
   endfunction

   // Mostly legal settings with the extremes, sometimes junk above the field
   function automatic logic [CSR_DW-1:0] pick_register_value(input csr_index_type index);
      logic [CSR_DW-1:0] v;
      logic [CSR_DW-1:0] keep;
      int                sel;
      sel = $urandom_range(9);
      case (index)
         REG_PATTERN: begin
            v    = $urandom_range(1);
            keep = 32'h1;
         end
         REG_SPEED: begin
            v    = (sel == 0) ? 1 : (sel == 1) ? 65535 : (sel == 2) ? 0 :
                   (sel < 5) ? SPEED_RESET : $urandom_range(65535, 1);
            keep = 32'hFFFF;
         end
         REG_BRIGHT: begin
            v    = (sel == 0) ? 0 : (sel < 4) ? BRIGHT_ONE :
                   (sel == 4) ? 8191 : $urandom_range(BRIGHT_ONE);
            keep = 32'h1FFF;
         end
         default: begin
            v    = (sel == 0) ? 1 : (sel == 1) ? 65535 : (sel == 2) ? 0 :
                   (sel < 5) ? FSCALE_RESET : $urandom_range(65535, 1);
            keep = 32'hFFFF;
         end
      endcase
      if ($urandom_range(7) == 0) v = v | ($urandom() & ~keep);
      return v;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_reset_values();
      csr_check(REG_PATTERN);
      csr_check(REG_SPEED);
      csr_check(REG_BRIGHT);
      csr_check(REG_FSCALE);
      // tick and stop while stopped leave the state alone
      send_request(KIND_TICK, 16'hFFFF, pick_level(), pick_level(), pick_level());
      send_request(KIND_STOP, 16'h0, pick_level(), pick_level(), pick_level());
   endtask

   task automatic test_register_rules();
      program_register(REG_SPEED, 0);
      program_register(REG_FSCALE, 0);
      program_register(REG_BRIGHT, 8191);
      // set color above full saturates the channel
      send_request(KIND_SET, 16'h0, 13'd8191, 13'd4096, 13'd0);
      program_register(REG_FSCALE, 65535);
      send_request(KIND_SET, 16'h0, 13'd4096, 13'd4096, 13'd4096);
      send_request(KIND_SET, 16'h0, 13'd0, 13'd0, 13'd0);
      program_register(REG_BRIGHT, 0);
      send_request(KIND_SET, 16'h0, 13'd4096, 13'd4096, 13'd4096);
      program_register(REG_BRIGHT, BRIGHT_ONE);
      program_register(REG_FSCALE, FSCALE_RESET);
   endtask

   task automatic test_ramp_cycle();
      program_register(REG_PATTERN, PAT_RAMP);
      program_register(REG_SPEED, 4096);
      send_request(KIND_START, 16'h0, 13'd0, 13'd0, 13'd0);
      // one whole phase per tick, ending exactly on each limit
      repeat (6) send_request(KIND_TICK, 16'd1, 13'd0, 13'd0, 13'd0);
      send_request(KIND_TICK, 16'hFFFF, 13'd0, 13'd0, 13'd0);
      send_request(KIND_TICK, 16'h0, 13'd0, 13'd0, 13'd0);
   endtask

   task automatic test_crossfade();
      program_register(REG_PATTERN, PAT_XFADE);
      program_register(REG_SPEED, 3000);
      send_request(KIND_START, 16'h0, 13'd0, 13'd0, 13'd0);
      // a partial step, then steps that overshoot across phase boundaries
      repeat (3) send_request(KIND_TICK, 16'd1, 13'd0, 13'd0, 13'd0);
      send_request(KIND_TICK, 16'd2, 13'd0, 13'd0, 13'd0);
   endtask

   task automatic test_pattern_switch();
      program_register(REG_PATTERN, PAT_RAMP);
      program_register(REG_SPEED, 4096);
      send_request(KIND_START, 16'h0, 13'd0, 13'd0, 13'd0);
      send_request(KIND_TICK, 16'd3, 13'd0, 13'd0, 13'd0);
      // crossfade with the phase out of its range restarts the walk
      program_register(REG_PATTERN, PAT_XFADE);
      send_request(KIND_TICK, 16'd0, 13'd0, 13'd0, 13'd0);
      program_register(REG_PATTERN, PAT_RAMP);
      program_register(REG_SPEED, 65535);
      send_request(KIND_TICK, 16'hFFFF, 13'd0, 13'd0, 13'd0);
      // set color stops the cycle and keeps the phase
      send_request(KIND_SET, 16'h0, 13'd100, 13'd200, 13'd300);
   endtask

   task automatic test_back_pressure();
      set_idling(0, 0);
      program_register(REG_SPEED, 1500);
      send_request(KIND_START, 16'h0, 13'd0, 13'd0, 13'd0);
      // hold results off while requests keep coming
      @(posedge clock);
      hold_left = 300;
      @(negedge clock);
      repeat (10) send_request(KIND_TICK, pick_elapsed(), pick_level(), pick_level(),
                               pick_level());
      wait_drain();
      repeat (5) send_request(KIND_TICK, pick_elapsed(), pick_level(), pick_level(),
                              pick_level());
      wait_drain();
   endtask

   task automatic test_random_traffic();
      int       phase_num;
      int       n;
      int       sel;
      int       idx;
      kind_type kind;
      for (phase_num = 0; phase_num < RANDOM_PHASES; phase_num++) begin
         case (phase_num % 4)
            0:       set_idling(0, 0);
            1:       set_idling(64, 0);
            2:       set_idling(0, 64);
            default: set_idling(25, 25);
         endcase
         for (idx = 0; idx < 4; idx++) begin
            program_register(csr_index_type'(idx), pick_register_value(csr_index_type'(idx)));
         end
         send_request(KIND_START, pick_elapsed(), pick_level(), pick_level(), pick_level());
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // now and then flip the pattern while the cycle runs
            if ($urandom_range(49) == 0) begin
               program_register(REG_PATTERN, {31'd0, ~pattern_q});
            end
            sel  = $urandom_range(99);
            kind = (sel < 75) ? KIND_TICK : (sel < 83) ? KIND_START :
                   (sel < 89) ? KIND_STOP : KIND_SET;
            send_request(kind, pick_elapsed(), pick_level(), pick_level(), pick_level());
         end
      end
      wait_drain();
   endtask

   initial begin
      fader_state_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_register_rules();
      test_ramp_cycle();
      test_crossfade();
      test_pattern_switch();
      test_back_pressure();
      test_random_traffic();

      wait_drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
design/rgbcf_pkg.sv
design/rgbcf_useq.sv
design/rgbcf_walk.sv
design/rgb_color_cycle_fader.sv
design/rgbcf_checker.sv
bench/tb_rgb_color_cycle_fader.sv
